// ----- sv/rgb_fade_cycler_with_button_modes_core_macros.svh -----
// Assertion macros used by the checker file of the fade cycler core.
`ifndef RGB_FADE_CYCLER_WITH_BUTTON_MODES_CORE_MACROS_SVH
`define RGB_FADE_CYCLER_WITH_BUTTON_MODES_CORE_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define RFC_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rfc assertion failed");

// Concurrent assertion that is checked on every clock edge.
`define RFC_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rfc assertion failed");

`endif

// ----- sv/rfc_pkg.sv -----
// Types and constants shared by the fade cycler core, its scaler and its checker.
`default_nettype none
package rfc_pkg;

    localparam int DUTY_W  = 9;
    localparam int WIDTH_W = 15;
    localparam int HOLD_W  = 8;
    localparam int STEP_W  = 9;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [DUTY_W-1:0]    t_duty;
    typedef logic [WIDTH_W-1:0]   t_width;
    typedef logic [HOLD_W-1:0]    t_hold;
    typedef logic [STEP_W-1:0]    t_step;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_AUTO  = 2'd0;
    localparam t_mode MODE_RED   = 2'd1;
    localparam t_mode MODE_BLUE  = 2'd2;
    localparam t_mode MODE_GREEN = 2'd3;

    localparam t_cfg_idx CFG_PERIOD_LOAD = 2'd0;
    localparam t_cfg_idx CFG_HOLD_TICKS  = 2'd1;
    localparam t_cfg_idx CFG_MAX_STEP    = 2'd2;

    localparam int PERIOD_LOAD_RESET = 11362;
    localparam t_hold HOLD_TICKS_RESET = 8'd30;
    localparam t_step MAX_STEP_RESET   = 9'd400;

    localparam t_duty DUTY_MIN  = 9'd10;
    localparam t_duty DUTY_MAX  = 9'd260;
    localparam t_duty DUTY_TURN = 9'd254;
    localparam t_duty RED_RESET   = 9'd260;
    localparam t_duty GREEN_RESET = 9'd10;
    localparam t_duty BLUE_RESET  = 9'd10;

    localparam t_step STEP_MIN   = 9'd10;
    localparam t_step STEP_DELTA = 9'd2;
    localparam t_step STEP_RESET = 9'd20;

    localparam logic [2:0] RISING_RESET = 3'b110;
    localparam logic [2:0] ACTIVE_RESET = 3'b011;

    // Division of the step by ten: multiply by 205 and shift right by 11 is exact below 1029.
    localparam int RECIP10       = 205;
    localparam int RECIP10_SHIFT = 11;

    localparam int WIDTH_DIV = 1000;

endpackage
`default_nettype wire

// ----- sv/rfc_scale.sv -----
// Two-stage scaler: pulse width equals duty times period load over one thousand.
`default_nettype none
module rfc_scale #(
    parameter int LOAD_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  rfc_pkg::t_duty       i_duty,
    input  wire [LOAD_BITS-1:0]  i_load,
    output rfc_pkg::t_width      o_width
);
    import rfc_pkg::*;

    localparam int PROD_W  = DUTY_W + LOAD_BITS;
    localparam int RECIP_W = PROD_W + 1;
    localparam int FULL_W  = PROD_W + RECIP_W;
    localparam int SHIFT   = PROD_W + 10;
    localparam logic [63:0] RECIP_64 =
        ((64'd1 << SHIFT) + 64'(WIDTH_DIV - 1)) / 64'(WIDTH_DIV);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_64[RECIP_W-1:0];

    logic [PROD_W-1:0] r_prod;
    t_width            r_width;
    logic [FULL_W-1:0] w_full;
    logic [FULL_W-1:0] w_quot;

    assign w_full  = FULL_W'(r_prod) * FULL_W'(RECIP);
    assign w_quot  = w_full >> SHIFT;
    assign o_width = r_width;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PROD_W'(i_duty) * PROD_W'(i_load);
            r_width <= w_quot[WIDTH_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- sv/rgb_fade_cycler_with_button_modes_core.sv -----
// An accepted beat updates the duty state; its valid flag then moves through r_va, r_vb and r_vc.
// Throughput: one beat per cycle while no result beat is stalled; the pulse widths pass
// through a registered multiply by the period load and a registered reciprocal
// multiply by 1/1000. Reset is synchronous and active low; it restores the duties,
// flags, step, press counters, mode and configuration registers and empties the pipeline.
`default_nettype none
module rgb_fade_cycler_with_button_modes_core #(
    parameter int COUNTER_BITS = 8,
    parameter int LOAD_BITS    = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  rfc_pkg::t_cfg_idx   i_cfg_addr,
    input  wire [((LOAD_BITS > rfc_pkg::STEP_W) ? LOAD_BITS : rfc_pkg::STEP_W)-1:0] i_cfg_data,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire                 i_sw1_pressed,
    input  wire                 i_sw2_pressed,
    output logic                o_valid,
    input  wire                 i_stall,
    output rfc_pkg::t_width     o_red_width,
    output rfc_pkg::t_width     o_green_width,
    output rfc_pkg::t_width     o_blue_width,
    output rfc_pkg::t_duty      o_red_level,
    output rfc_pkg::t_duty      o_green_level,
    output rfc_pkg::t_duty      o_blue_level,
    output rfc_pkg::t_mode      o_mode
);
    import rfc_pkg::*;

    localparam int CMP_W = (COUNTER_BITS > HOLD_W) ? COUNTER_BITS : HOLD_W;
    localparam logic [COUNTER_BITS-1:0] CNT_TOP = '1;

    logic [LOAD_BITS-1:0]    r_period;
    t_hold                   r_hold;
    t_step                   r_max_step;

    t_mode                   r_mode, n_mode;
    t_duty                   r_duty [3];
    t_duty                   n_duty [3];
    logic [2:0]              r_rising, n_rising;
    logic [2:0]              r_active, n_active;
    t_step                   r_step, n_step;
    logic [COUNTER_BITS-1:0] r_press1, n_press1;
    logic [COUNTER_BITS-1:0] r_press2, n_press2;
    logic                    r_seen, n_seen;
    logic                    r_first, n_first;
    logic                    r_second, n_second;

    logic                    r_va, r_vb, r_vc;
    t_duty                   r_b_duty [3];
    t_duty                   r_c_duty [3];
    t_mode                   r_b_mode, r_c_mode;

    logic                    w_en, w_accept;
    logic                    w_p1_long, w_p2_long, w_p1_nz;
    logic [17:0]             w_inc_prod, w_dec_prod;
    logic [5:0]              w_inc;
    logic [6:0]              w_dec;

    assign w_en     = !(r_vc && i_stall);
    assign w_accept = i_valid && w_en;
    assign o_stall  = !w_en;
    assign o_valid  = r_vc;

    assign w_p1_long = CMP_W'(r_press1) >= CMP_W'(r_hold);
    assign w_p2_long = CMP_W'(r_press2) >= CMP_W'(r_hold);
    assign w_p1_nz   = r_press1 != '0;

    assign w_inc_prod = 18'(r_step) * 18'(RECIP10);
    assign w_dec_prod = (18'(r_step) + 18'(9)) * 18'(RECIP10);
    assign w_inc      = w_inc_prod[RECIP10_SHIFT +: 6];
    assign w_dec      = w_dec_prod[RECIP10_SHIFT +: 7];

    always_comb begin
        logic [9:0] sum;
        logic [1:0] nxt;
        logic [1:0] prv;
        logic [1:0] sel;
        t_duty      d;

        n_mode   = r_mode;
        n_duty   = r_duty;
        n_rising = r_rising;
        n_active = r_active;
        n_step   = r_step;
        n_press1 = r_press1;
        n_press2 = r_press2;
        n_seen   = r_seen;
        n_first  = r_first;
        n_second = r_second;
        sum      = '0;
        nxt      = '0;
        prv      = '0;
        sel      = '0;
        d        = '0;

        if (i_sw1_pressed) begin
            if (r_press1 != CNT_TOP) begin
                n_press1 = r_press1 + COUNTER_BITS'(1);
            end
            n_seen = 1'b1;
        end else begin
            if (r_seen) begin
                if (r_first) begin
                    n_second = 1'b1;
                end else begin
                    n_first = 1'b1;
                end
                n_seen = 1'b0;
            end
            if (w_p2_long && !w_p1_long && w_p1_nz && n_first && !n_second) begin
                n_mode = MODE_RED;
            end else if (w_p2_long && w_p1_nz && !w_p1_long && n_second) begin
                n_mode = MODE_BLUE;
            end else if (w_p1_long && w_p2_long) begin
                n_mode = MODE_GREEN;
            end
            n_press1 = '0;
        end

        if (i_sw2_pressed) begin
            if (r_press2 != CNT_TOP) begin
                n_press2 = r_press2 + COUNTER_BITS'(1);
            end
        end else begin
            if ((CMP_W'(n_press1) >= CMP_W'(r_hold)) && w_p2_long) begin
                n_mode = MODE_GREEN;
            end
            n_press2 = '0;
            n_first  = 1'b0;
            n_second = 1'b0;
        end

        if (n_mode == MODE_AUTO) begin
            for (int c = 0; c < 3; c++) begin
                nxt = (c == 2) ? 2'd0 : 2'(c + 1);
                prv = (c == 0) ? 2'd2 : 2'(c - 1);
                if (n_active[c]) begin
                    if (n_rising[c]) begin
                        sum = 10'(n_duty[c]) + 10'(w_inc);
                        if (sum >= 10'(DUTY_MAX)) begin
                            n_duty[c]     = DUTY_TURN;
                            n_rising[c]   = 1'b0;
                            n_active[prv] = 1'b0;
                            n_active[nxt] = 1'b1;
                        end else begin
                            n_duty[c] = sum[DUTY_W-1:0];
                        end
                    end else begin
                        if (10'(n_duty[c]) <= 10'(w_dec) + 10'(DUTY_MIN)) begin
                            n_duty[c]     = DUTY_MIN;
                            n_rising[c]   = 1'b1;
                            n_active[c]   = 1'b0;
                            n_active[prv] = 1'b1;
                        end else begin
                            n_duty[c] = n_duty[c] - DUTY_W'(w_dec);
                        end
                    end
                end
            end
            if (i_sw1_pressed) begin
                n_step = (n_step <= STEP_MIN + STEP_DELTA) ? STEP_MIN : n_step - STEP_DELTA;
            end
            if (i_sw2_pressed) begin
                sum = 10'(n_step) + 10'(STEP_DELTA);
                if (sum >= 10'(r_max_step)) begin
                    n_step = r_max_step;
                end else begin
                    n_step = sum[STEP_W-1:0];
                end
            end
        end else begin
            case (n_mode)
                MODE_RED: begin
                    sel = 2'd0;
                end
                MODE_BLUE: begin
                    sel = 2'd2;
                end
                default: begin
                    sel = 2'd1;
                end
            endcase
            d = n_duty[sel];
            if (i_sw1_pressed) begin
                d = (d <= DUTY_MIN + 9'd1) ? DUTY_MIN : d - 9'd1;
            end
            if (i_sw2_pressed) begin
                d = (d >= DUTY_MAX - 9'd1) ? DUTY_MAX : d + 9'd1;
            end
            n_duty[sel] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= LOAD_BITS'(PERIOD_LOAD_RESET);
            r_hold     <= HOLD_TICKS_RESET;
            r_max_step <= MAX_STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PERIOD_LOAD: begin
                    r_period <= i_cfg_data[LOAD_BITS-1:0];
                end
                CFG_HOLD_TICKS: begin
                    r_hold <= i_cfg_data[HOLD_W-1:0];
                end
                CFG_MAX_STEP: begin
                    r_max_step <= i_cfg_data[STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_AUTO;
            r_duty[0] <= RED_RESET;
            r_duty[1] <= GREEN_RESET;
            r_duty[2] <= BLUE_RESET;
            r_rising  <= RISING_RESET;
            r_active  <= ACTIVE_RESET;
            r_step    <= STEP_RESET;
            r_press1  <= '0;
            r_press2  <= '0;
            r_seen    <= 1'b0;
            r_first   <= 1'b0;
            r_second  <= 1'b0;
        end else if (w_accept) begin
            r_mode   <= n_mode;
            r_duty   <= n_duty;
            r_rising <= n_rising;
            r_active <= n_active;
            r_step   <= n_step;
            r_press1 <= n_press1;
            r_press2 <= n_press2;
            r_seen   <= n_seen;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (w_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_duty <= r_duty;
            r_b_mode <= r_mode;
            r_c_duty <= r_b_duty;
            r_c_mode <= r_b_mode;
        end
    end

    rfc_scale #(.LOAD_BITS(LOAD_BITS)) u_scale_red (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_duty  (r_duty[0]),
        .i_load  (r_period),
        .o_width (o_red_width)
    );

    rfc_scale #(.LOAD_BITS(LOAD_BITS)) u_scale_green (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_duty  (r_duty[1]),
        .i_load  (r_period),
        .o_width (o_green_width)
    );

    rfc_scale #(.LOAD_BITS(LOAD_BITS)) u_scale_blue (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_duty  (r_duty[2]),
        .i_load  (r_period),
        .o_width (o_blue_width)
    );

    assign o_red_level   = r_c_duty[0];
    assign o_green_level = r_c_duty[1];
    assign o_blue_level  = r_c_duty[2];
    assign o_mode        = r_c_mode;

endmodule
`default_nettype wire

// ----- sv/rfc_checker.sv -----
// Port-level checker for the fade cycler core and the bind that attaches it.
`default_nettype none
`include "rgb_fade_cycler_with_button_modes_core_macros.svh"
module rfc_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             o_stall,
    input wire             o_valid,
    input wire             i_stall,
    input rfc_pkg::t_width o_red_width,
    input rfc_pkg::t_duty  o_red_level,
    input rfc_pkg::t_duty  o_green_level,
    input rfc_pkg::t_duty  o_blue_level,
    input rfc_pkg::t_mode  o_mode
);
    import rfc_pkg::*;

    logic                                 w_out_wait;
    logic                                 w_manual;
    logic                                 w_levels_ok;
    logic [WIDTH_W+3*DUTY_W+MODE_W-1:0]   w_payload;

    assign w_out_wait  = o_valid && i_stall;
    assign w_manual    = o_valid && (o_mode != MODE_AUTO);
    assign w_payload   = {o_red_width, o_red_level, o_green_level, o_blue_level, o_mode};
    assign w_levels_ok = (o_red_level >= DUTY_MIN) && (o_red_level <= DUTY_MAX) &&
                         (o_green_level >= DUTY_MIN) && (o_green_level <= DUTY_MAX) &&
                         (o_blue_level >= DUTY_MIN) && (o_blue_level <= DUTY_MAX);

    // A stalled result beat stays offered with the same payload.
    `RFC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, w_out_wait |=> (o_valid && $stable(w_payload)))

    // The input side is only held back by a result beat that cannot leave.
    `RFC_ASSERT(a_stall_cause, i_clk, o_stall |-> (o_valid && i_stall))

    // Every duty shown stays within its permitted span.
    `RFC_ASSERT_RST(a_level_span, i_clk, i_rst_n, o_valid |-> w_levels_ok)

    // Once a manual mode is shown, auto fade never returns.
    `RFC_ASSERT_RST(a_mode_sticky, i_clk, i_rst_n, w_manual |=> (o_mode != MODE_AUTO))

endmodule

bind rgb_fade_cycler_with_button_modes_core rfc_checker u_rfc_checker (.*);
`default_nettype wire
